// ===== hdl/vsn_pkg.sv =====
`timescale 1ns / 1ps

package vsn_pkg;

  // Fixed field widths
  localparam int COORD_W = 24;
  localparam int INDEX_W = 8;
  localparam int DATA_W  = 16;
  localparam int PERM_W  = 8;
  localparam int FUNC_W  = 2;

  // Item function codes; the fourth code is ignored
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_PERM   = 2'd1,
    FUNC_VALUE  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Hash offset added to a permutation read pair
  typedef enum logic [2:0] {
    HSEL_ZERO,
    HSEL_Z0,
    HSEL_Z1,
    HSEL_Y00,
    HSEL_Y10,
    HSEL_Y01,
    HSEL_Y11
  } hsel_t;

  // Operand source of the blend unit
  typedef enum logic [1:0] {
    LSRC_LAT,
    LSRC_X01,
    LSRC_X23,
    LSRC_Y01
  } lsrc_t;

  typedef struct packed {
    logic       clear_we;
    logic       perm_we;
    logic       lat_we;
    logic       cap_coord;
    axis_t      pair_base;
    hsel_t      pair_hsel;
    logic       hreg_we;
    logic [1:0] hreg_pair;
    logic       lerp_go;
    lsrc_t      lerp_src;
    axis_t      lerp_axis;
    logic       br_we;
    logic [2:0] br_idx;
    logic       out_load;
  } vsn_cmd_t;

  typedef struct packed {
    logic clear_last;
  } vsn_stat_t;

endpackage

// ===== hdl/vsn_ctrl.sv =====
`timescale 1ns / 1ps

module vsn_ctrl
  import vsn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic                out_ready,
  output logic                out_valid,
  input  vsn_stat_t           stat,
  output vsn_cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

  // Sequencer positions of one sample
  localparam logic [4:0] STEP_HASH_Z  = 5'd0;
  localparam logic [4:0] STEP_WAIT_Z  = 5'd1;
  localparam logic [4:0] STEP_HASH_Y0 = 5'd2;
  localparam logic [4:0] STEP_HASH_Y1 = 5'd3;
  localparam logic [4:0] STEP_HASH_X0 = 5'd4;
  localparam logic [4:0] STEP_HASH_X1 = 5'd5;
  localparam logic [4:0] STEP_HASH_X2 = 5'd6;
  localparam logic [4:0] STEP_HASH_X3 = 5'd7;
  localparam logic [4:0] STEP_LERP_X2 = 5'd8;
  localparam logic [4:0] STEP_LERP_X3 = 5'd9;
  localparam logic [4:0] STEP_LERP_Y0 = 5'd10;
  localparam logic [4:0] STEP_CAP_X3  = 5'd11;
  localparam logic [4:0] STEP_LERP_Y1 = 5'd12;
  localparam logic [4:0] STEP_GAP_A   = 5'd13;
  localparam logic [4:0] STEP_CAP_Y1  = 5'd14;
  localparam logic [4:0] STEP_LERP_Z  = 5'd15;
  localparam logic [4:0] STEP_GAP_B   = 5'd16;
  localparam logic [4:0] STEP_DONE    = 5'd17;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode state and step into datapath commands
  always_comb begin
    cmd            = '0;
    state_next     = state;
    step_next      = step;
    case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_SAMPLE: begin
              cmd.cap_coord = 1'b1;
              state_next    = ST_RUN;
              step_next     = STEP_HASH_Z;
            end
            FUNC_PERM:  cmd.perm_we = 1'b1;
            FUNC_VALUE: cmd.lat_we  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        step_next = step + 5'd1;
        case (step)
          STEP_HASH_Z: begin
            cmd.pair_base = AXIS_Z;
            cmd.pair_hsel = HSEL_ZERO;
          end
          STEP_WAIT_Z: begin
            cmd.hreg_we   = 1'b1;
            cmd.hreg_pair = 2'd0;
          end
          STEP_HASH_Y0: begin
            cmd.pair_base = AXIS_Y;
            cmd.pair_hsel = HSEL_Z0;
          end
          STEP_HASH_Y1: begin
            cmd.pair_base = AXIS_Y;
            cmd.pair_hsel = HSEL_Z1;
            cmd.hreg_we   = 1'b1;
            cmd.hreg_pair = 2'd1;
          end
          STEP_HASH_X0: begin
            cmd.pair_base = AXIS_X;
            cmd.pair_hsel = HSEL_Y00;
            cmd.hreg_we   = 1'b1;
            cmd.hreg_pair = 2'd2;
          end
          STEP_HASH_X1: begin
            cmd.pair_base = AXIS_X;
            cmd.pair_hsel = HSEL_Y10;
          end
          STEP_HASH_X2: begin
            cmd.pair_base = AXIS_X;
            cmd.pair_hsel = HSEL_Y01;
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_LAT;
            cmd.lerp_axis = AXIS_X;
          end
          STEP_HASH_X3: begin
            cmd.pair_base = AXIS_X;
            cmd.pair_hsel = HSEL_Y11;
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_LAT;
            cmd.lerp_axis = AXIS_X;
          end
          STEP_LERP_X2: begin
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_LAT;
            cmd.lerp_axis = AXIS_X;
            cmd.br_we     = 1'b1;
            cmd.br_idx    = 3'd0;
          end
          STEP_LERP_X3: begin
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_LAT;
            cmd.lerp_axis = AXIS_X;
            cmd.br_we     = 1'b1;
            cmd.br_idx    = 3'd1;
          end
          STEP_LERP_Y0: begin
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_X01;
            cmd.lerp_axis = AXIS_Y;
            cmd.br_we     = 1'b1;
            cmd.br_idx    = 3'd2;
          end
          STEP_CAP_X3: begin
            cmd.br_we  = 1'b1;
            cmd.br_idx = 3'd3;
          end
          STEP_LERP_Y1: begin
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_X23;
            cmd.lerp_axis = AXIS_Y;
            cmd.br_we     = 1'b1;
            cmd.br_idx    = 3'd4;
          end
          STEP_GAP_A: ;
          STEP_CAP_Y1: begin
            cmd.br_we  = 1'b1;
            cmd.br_idx = 3'd5;
          end
          STEP_LERP_Z: begin
            cmd.lerp_go   = 1'b1;
            cmd.lerp_src  = LSRC_Y01;
            cmd.lerp_axis = AXIS_Z;
          end
          STEP_GAP_B: ;
          STEP_DONE: begin
            // Hold here until the output register is free
            if (!out_valid || out_ready) begin
              cmd.out_load = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              step_next = step;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Track the output register's valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= STEP_HASH_Z;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/vsn_lerp.sv =====
`timescale 1ns / 1ps

module vsn_lerp
  import vsn_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 go,
  input  logic [DATA_W-1:0]    a,
  input  logic [DATA_W-1:0]    b,
  input  logic [FRAC_BITS-1:0] t,
  output logic [DATA_W-1:0]    result
);

  localparam int PROD_W = FRAC_BITS + DATA_W;

  logic [DATA_W-1:0]    a1, mag1, a2, step_amt;
  logic                 neg1, neg2;
  logic [FRAC_BITS-1:0] t1;
  logic [PROD_W-1:0]    prod2;

  // Capture operands: magnitude and direction of b - a
  always_ff @(posedge clk) begin
    if (go) begin
      a1   <= a;
      neg1 <= (b < a);
      mag1 <= (b >= a) ? (b - a) : (a - b);
      t1   <= t;
    end
  end

  // Scale the span by the fraction
  always_ff @(posedge clk) begin
    a2    <= a1;
    neg2  <= neg1;
    prod2 <= PROD_W'(t1) * PROD_W'(mag1);
  end

  // Truncate the scaled span and step from a toward b
  assign step_amt = DATA_W'(prod2 >> FRAC_BITS);
  assign result   = neg2 ? (a2 - step_amt) : (a2 + step_amt);

endmodule

// ===== hdl/vsn_datapath.sv =====
`timescale 1ns / 1ps

module vsn_datapath
  import vsn_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  vsn_cmd_t            cmd,
  output vsn_stat_t           stat,
  input  logic [COORD_W-1:0]  coord_x,
  input  logic [COORD_W-1:0]  coord_y,
  input  logic [COORD_W-1:0]  coord_z,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [DATA_W-1:0]   entry_data,
  output logic [DATA_W-1:0]   noise_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_SIZE - 1);

  logic [COORD_W-1:0]   cx, cy, cz;
  logic [IDX_W-1:0]     clear_addr;
  logic [PERM_W-1:0]    perm_mem [TABLE_SIZE];
  logic [DATA_W-1:0]    lat_mem  [TABLE_SIZE];
  logic [PERM_W-1:0]    perm_rd_a, perm_rd_b;
  logic [DATA_W-1:0]    lat_rd_a, lat_rd_b;
  logic [PERM_W-1:0]    hreg [6];
  logic [DATA_W-1:0]    br   [6];

  logic [IDX_W-1:0]     wr_addr, base, pa_addr, pb_addr, la_addr, lb_addr;
  logic [PERM_W-1:0]    perm_wdata, hval;
  logic [DATA_W-1:0]    lat_wdata, op_a, op_b, lerp_out;
  logic                 perm_wen, lat_wen;
  logic [FRAC_BITS-1:0] op_t;

  // Latch the sample point
  always_ff @(posedge clk) begin
    if (cmd.cap_coord) begin
      cx <= coord_x;
      cy <= coord_y;
      cz <= coord_z;
    end
  end

  // Advance the clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_we) begin
      clear_addr <= clear_addr + IDX_W'(1);
    end
  end

  assign stat.clear_last = (clear_addr == IDX_W'(TABLE_SIZE - 1));

  // Shared write port: clearing sweep or load item
  assign wr_addr    = cmd.clear_we ? clear_addr : (IDX_W'(entry_index) & IDX_MASK);
  assign perm_wdata = cmd.clear_we ? PERM_W'(clear_addr) : entry_data[PERM_W-1:0];
  assign lat_wdata  = cmd.clear_we ? '0 : entry_data;
  assign perm_wen   = cmd.clear_we || cmd.perm_we;
  assign lat_wen    = cmd.clear_we || cmd.lat_we;

  // Select the lattice coordinate of the read pair
  always_comb begin
    case (cmd.pair_base)
      AXIS_Y:  base = IDX_W'(cy >> FRAC_BITS);
      AXIS_Z:  base = IDX_W'(cz >> FRAC_BITS);
      default: base = IDX_W'(cx >> FRAC_BITS);
    endcase
  end

  // Select the hash carried from the previous level
  always_comb begin
    case (cmd.pair_hsel)
      HSEL_Z0:  hval = hreg[0];
      HSEL_Z1:  hval = hreg[1];
      HSEL_Y00: hval = hreg[2];
      HSEL_Y10: hval = hreg[3];
      HSEL_Y01: hval = hreg[4];
      HSEL_Y11: hval = hreg[5];
      default:  hval = '0;
    endcase
  end

  // Read the lower and upper corner of one axis at once
  assign pa_addr = (base + IDX_W'(hval)) & IDX_MASK;
  assign pb_addr = (base + IDX_W'(1) + IDX_W'(hval)) & IDX_MASK;

  // Lattice reads follow the last permutation level directly
  assign la_addr = IDX_W'(perm_rd_a) & IDX_MASK;
  assign lb_addr = IDX_W'(perm_rd_b) & IDX_MASK;

  always_ff @(posedge clk) begin
    if (perm_wen) begin
      perm_mem[wr_addr] <= perm_wdata;
    end
    perm_rd_a <= perm_mem[pa_addr];
    perm_rd_b <= perm_mem[pb_addr];
  end

  always_ff @(posedge clk) begin
    if (lat_wen) begin
      lat_mem[wr_addr] <= lat_wdata;
    end
    lat_rd_a <= lat_mem[la_addr];
    lat_rd_b <= lat_mem[lb_addr];
  end

  // Hold intermediate hashes for the next level
  always_ff @(posedge clk) begin
    if (cmd.hreg_we) begin
      hreg[{cmd.hreg_pair, 1'b0}] <= perm_rd_a;
      hreg[{cmd.hreg_pair, 1'b1}] <= perm_rd_b;
    end
  end

  // Route blend operands
  always_comb begin
    case (cmd.lerp_src)
      LSRC_X01: begin
        op_a = br[0];
        op_b = br[1];
      end
      LSRC_X23: begin
        op_a = br[2];
        op_b = br[3];
      end
      LSRC_Y01: begin
        op_a = br[4];
        op_b = br[5];
      end
      default: begin
        op_a = lat_rd_a;
        op_b = lat_rd_b;
      end
    endcase
  end

  always_comb begin
    case (cmd.lerp_axis)
      AXIS_Y:  op_t = cy[FRAC_BITS-1:0];
      AXIS_Z:  op_t = cz[FRAC_BITS-1:0];
      default: op_t = cx[FRAC_BITS-1:0];
    endcase
  end

  vsn_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .go     (cmd.lerp_go),
    .a      (op_a),
    .b      (op_b),
    .t      (op_t),
    .result (lerp_out)
  );

  // Keep partial blends
  always_ff @(posedge clk) begin
    if (cmd.br_we) begin
      br[cmd.br_idx] <= lerp_out;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      noise_value <= lerp_out;
    end
  end

endmodule

// ===== hdl/value_noise_3d_sampler.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------------
// in       in_valid / in_ready  func, coord_x, coord_y, coord_z, entry_index, entry_data
// out      out_valid/out_ready  noise_value
//
// Load items (func 1 and 2) and the unused func code leave in_ready high.
// A sample closes the input until its result is loaded: three dependent permutation
// reads through two read ports, the lattice read, then seven blends through one shared
// two-stage multiply unit.
// After reset the tables are swept with in_ready low.
// A full output register stalls only the last step of the next sample; loads still transfer.

module value_noise_3d_sampler
  import vsn_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [COORD_W-1:0]  coord_x,
  input  logic [COORD_W-1:0]  coord_y,
  input  logic [COORD_W-1:0]  coord_z,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [DATA_W-1:0]   entry_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   noise_value
);

  vsn_cmd_t  cmd;
  vsn_stat_t stat;

  vsn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  vsn_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .entry_index (entry_index),
    .entry_data  (entry_data),
    .noise_value (noise_value)
  );

endmodule

// ===== hdl/vsn_checker.sv =====
`timescale 1ns / 1ps

module vsn_checker
  import vsn_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FUNC_W-1:0]  func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  noise_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("result changed while stalled");

  // The table sweep follows reset with input closed
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open right after reset");

  // A sample transfer closes the input
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_SAMPLE |=> !in_ready)
    else $error("input open after sample transfer");

  // A load or ignored item keeps the input open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func != FUNC_SAMPLE |=> in_ready)
    else $error("input closed after load transfer");

  // A new result appears only at the end of a busy stretch
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind value_noise_3d_sampler vsn_checker u_vsn_checker (.*);

// ===== tb/noise_sample_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, tracks the two tables, and checks every noise result
// against the value the same table contents should give.
module noise_sample_checker
  import vsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FUNC_W-1:0]  func,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [DATA_W-1:0]  entry_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [DATA_W-1:0]  noise_value,
  output int                 mismatch_count,
  output int                 noise_pending
);

  localparam int LATTICE_DEPTH = 256;

  logic [PERM_W-1:0] perm_model    [LATTICE_DEPTH];
  logic [DATA_W-1:0] lattice_model [LATTICE_DEPTH];
  logic [DATA_W-1:0] noise_expect_q[$];
  logic [DATA_W-1:0] noise_expected;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] noise check: %s", $realtime, msg);
  endtask

  // Step from a toward b by t (Q0.16), truncating toward a
  function automatic logic [DATA_W-1:0] lerp_q16(input logic [15:0] t,
                                                 input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [31:0] prod;
    if (b >= a) begin
      prod = 32'(t) * 32'(b - a);
      return a + prod[31:16];
    end
    prod = 32'(t) * 32'(a - b);
    return a - prod[31:16];
  endfunction

  // Hash one cube corner through the permutation table; 8-bit sums wrap
  function automatic logic [DATA_W-1:0] corner_lattice(input logic [7:0] x,
                                                       input logic [7:0] y,
                                                       input logic [7:0] z);
    logic [7:0] hz;
    logic [7:0] hy;
    logic [7:0] hx;
    hz = perm_model[z];
    hy = y + hz;
    hy = perm_model[hy];
    hx = x + hy;
    hx = perm_model[hx];
    return lattice_model[hx];
  endfunction

  function automatic logic [DATA_W-1:0] trilinear_noise(input logic [COORD_W-1:0] cx,
                                                        input logic [COORD_W-1:0] cy,
                                                        input logic [COORD_W-1:0] cz);
    logic [7:0] ix0, iy0, iz0, ix1, iy1, iz1;
    logic [DATA_W-1:0] bx0, bx1, bx2, bx3, by0, by1;
    ix0 = cx[23:16];
    iy0 = cy[23:16];
    iz0 = cz[23:16];
    ix1 = ix0 + 8'd1;
    iy1 = iy0 + 8'd1;
    iz1 = iz0 + 8'd1;
    bx0 = lerp_q16(cx[15:0], corner_lattice(ix0, iy0, iz0), corner_lattice(ix1, iy0, iz0));
    bx1 = lerp_q16(cx[15:0], corner_lattice(ix0, iy1, iz0), corner_lattice(ix1, iy1, iz0));
    bx2 = lerp_q16(cx[15:0], corner_lattice(ix0, iy0, iz1), corner_lattice(ix1, iy0, iz1));
    bx3 = lerp_q16(cx[15:0], corner_lattice(ix0, iy1, iz1), corner_lattice(ix1, iy1, iz1));
    by0 = lerp_q16(cy[15:0], bx0, bx1);
    by1 = lerp_q16(cy[15:0], bx2, bx3);
    return lerp_q16(cz[15:0], by0, by1);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LATTICE_DEPTH; i++) begin
        perm_model[i]    = i[PERM_W-1:0];
        lattice_model[i] = '0;
      end
      noise_expect_q.delete();
    end else begin
      // Compare a result transfer with the oldest pending sample
      if (out_valid && out_ready) begin
        if (noise_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result noise_value=%h", noise_value));
        end else begin
          noise_expected = noise_expect_q.pop_front();
          if (noise_value !== noise_expected)
            report_mismatch($sformatf("noise_value=%h, expected %h",
                                      noise_value, noise_expected));
        end
      end
      // Apply loads to the table copies, predict samples
      if (in_valid && in_ready) begin
        case (func)
          FUNC_PERM:   perm_model[entry_index] = entry_data[PERM_W-1:0];
          FUNC_VALUE:  lattice_model[entry_index] = entry_data;
          FUNC_SAMPLE: noise_expect_q.push_back(trilinear_noise(coord_x, coord_y, coord_z));
          default:     ;
        endcase
      end
    end
    noise_pending = noise_expect_q.size();
  end

endmodule

// ===== tb/tb_value_noise_3d_sampler.sv =====
`timescale 1ns / 1ps

module tb_value_noise_3d_sampler;
  import vsn_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 30;
  localparam int ITEMS_PER_PHASE  = 340;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func        = '0;
  logic [COORD_W-1:0] coord_x     = '0;
  logic [COORD_W-1:0] coord_y     = '0;
  logic [COORD_W-1:0] coord_z     = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic [DATA_W-1:0]  entry_data  = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [DATA_W-1:0]  noise_value;

  int mismatch_count;
  int noise_pending;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;

  value_noise_3d_sampler u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .entry_index (entry_index),
    .entry_data  (entry_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
  );

  noise_sample_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .entry_index    (entry_index),
    .entry_data     (entry_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .noise_value    (noise_value),
    .mismatch_count (mismatch_count),
    .noise_pending  (noise_pending)
  );

  always #5 clk = ~clk;

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Offer one item after a random idle gap; hold it until the transfer
  task automatic send_item(input logic [FUNC_W-1:0] f,
                           input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z,
                           input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    entry_index <= idx;
    entry_data  <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every pending sample has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (noise_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_any_coord();
    return COORD_W'($urandom_range(24'hFFFFFF));
  endfunction

  function automatic logic [INDEX_W-1:0] rand_index();
    return INDEX_W'($urandom_range(255));
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    return DATA_W'($urandom_range(16'hFFFF));
  endfunction

  // Bias toward lattice edges: zero or full fraction, top cell
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = COORD_W'($urandom_range(24'hFFFFFF));
    case ($urandom_range(7))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[23:16] = 8'hFF;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] rand_lattice();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return DATA_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Mostly samples, then value and permutation loads, a few unused codes
  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_item(FUNC_SAMPLE, rand_coord(), rand_coord(), rand_coord(),
                  rand_index(), rand_data());
        sent++;
      end else if (pick < 72) begin
        send_item(FUNC_VALUE, rand_any_coord(), rand_any_coord(),
                  rand_any_coord(), rand_index(), rand_lattice());
        sent++;
      end else if (pick < 95) begin
        send_item(FUNC_PERM, rand_any_coord(), rand_any_coord(),
                  rand_any_coord(), rand_index(), rand_data());
        sent++;
      end else begin
        send_item(FUNC_UNUSED, rand_any_coord(), rand_any_coord(),
                  rand_any_coord(), rand_index(), rand_data());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: table edges, wrap at the top cell, fraction extremes
    send_item(FUNC_SAMPLE, 24'h000000, 24'h000000, 24'h000000, 8'hFF, 16'hFFFF);
    send_item(FUNC_VALUE,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   16'hFFFF);
    send_item(FUNC_VALUE,  24'h000000, 24'h000000, 24'h000000, 8'd1,   16'h0001);
    send_item(FUNC_VALUE,  24'h000000, 24'h000000, 24'h000000, 8'hFF,  16'h8000);
    send_item(FUNC_VALUE,  24'h000000, 24'h000000, 24'h000000, 8'd128, 16'h1234);
    send_item(FUNC_SAMPLE, 24'h000000, 24'h000000, 24'h000000, 8'h00, 16'h0000);
    send_item(FUNC_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 16'h0000);
    send_item(FUNC_SAMPLE, 24'h00FFFF, 24'h000000, 24'h000000, 8'hA5, 16'h5A5A);
    send_item(FUNC_SAMPLE, 24'h000000, 24'h00FFFF, 24'h000000, 8'h00, 16'h0000);
    send_item(FUNC_SAMPLE, 24'h000000, 24'h000000, 24'h00FFFF, 8'h00, 16'h0000);
    send_item(FUNC_SAMPLE, 24'hFF8000, 24'hFF8000, 24'hFF8000, 8'h00, 16'h0000);
    // Permutation load keeps only the low byte
    send_item(FUNC_PERM,   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   16'hFF01);
    send_item(FUNC_PERM,   24'h000000, 24'h000000, 24'h000000, 8'hFF,  16'h0000);
    send_item(FUNC_PERM,   24'h000000, 24'h000000, 24'h000000, 8'd7,   16'h00FF);
    send_item(FUNC_SAMPLE, 24'h000000, 24'h000000, 24'h000000, 8'h00, 16'h0000);
    send_item(FUNC_SAMPLE, 24'h070000, 24'hFFFFFF, 24'h008000, 8'h00, 16'h0000);
    // Unused code must not touch the tables
    send_item(FUNC_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   16'h0000);
    send_item(FUNC_UNUSED, 24'h000000, 24'h000000, 24'h000000, 8'd1,   16'hFFFF);
    send_item(FUNC_SAMPLE, 24'h000000, 24'h000000, 24'h000000, 8'hFF, 16'hFFFF);
    send_item(FUNC_SAMPLE, 24'hFF0001, 24'h00FFFF, 24'hFFFFFE, 8'h00, 16'h0000);
    drain_results();

    run_phase(ITEMS_PER_PHASE, 0, 0);
    run_phase(ITEMS_PER_PHASE, 83, 0);
    run_phase(ITEMS_PER_PHASE, 0, 83);
    run_phase(ITEMS_PER_PHASE, 32, 32);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
